[hw/rtl/chacha_pkg.sv]
// ----------------------------------------------------------------------------
// ChaCha20 shared definitions
// Constants, queue entry type and block-core helpers.
// ----------------------------------------------------------------------------
package chacha_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam int unsigned DOUBLE_ROUNDS = 10;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    // One classified item: byte, its offset, its block counter and whether it opens a new block
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] offset;
        logic       new_block;
        logic [63:0] counter;
    } item_t;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // One quarter round on four words
    function automatic logic [127:0] qr(input word_t a, input word_t b,
                                        input word_t c, input word_t d);
        word_t a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        qr = {a1, b1, c1, d1};
    endfunction

endpackage

[hw/rtl/chacha20_stream_cipher.sv]
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher (64-bit nonce, 64-bit counter)
// XORs each byte with the next keystream byte.
// ----------------------------------------------------------------------------
// Usage: write the key (indexes 0..3) and nonce (index 4) on cfg_we while
// idle. Bytes enter on in_valid/in_ready with restart set on the first byte
// of a message; each item yields one out_byte on out_valid/out_ready.
// The front end tracks offset and counter and queues up to four items. The
// back end computes a keystream block with one double round per cycle:
// the first byte of a block waits for the load, 10 double rounds and the
// final add, then each byte goes through the XOR stage. No byte is taken
// while a block is built by the single double-round unit. A mid-block
// byte passes through the queue and the output register before out_valid.
// Reset clears offset, counter, queue pointers and registers to zero.
// When the receiver stalls, the output register holds; the queue then
// fills and in_ready drops.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import chacha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte
);
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic  push, q_full, q_ne, pop, blk_done_reg;
    item_t push_item, head, head_eff;
    logic u_back_final;
    logic [4:0] gen_cnt_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0;
            key3_reg <= '0; nonce_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_KEY0:  key0_reg  <= cfg_wdata;
                REG_KEY1:  key1_reg  <= cfg_wdata;
                REG_KEY2:  key2_reg  <= cfg_wdata;
                REG_KEY3:  key3_reg  <= cfg_wdata;
                REG_NONCE: nonce_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    chacha_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .data_byte, .restart,
        .push, .push_item, .q_full
    );

    chacha_queue u_queue (
        .clk, .rst_n, .push, .push_item, .full(q_full),
        .pop, .not_empty(q_ne), .head
    );

    // Mark the head's block as built once generation finishes; clear on pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blk_done_reg <= 1'b0;
        else if (pop)
            blk_done_reg <= 1'b0;
        else if (u_back_final)
            blk_done_reg <= 1'b1;
    end

    // Count generation cycles to know when the block is in place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gen_cnt_reg <= '0;
        else if (q_ne && head.new_block && !blk_done_reg)
            gen_cnt_reg <= (gen_cnt_reg == 5'd11) ? 5'd0 : gen_cnt_reg + 5'd1;
    end
    assign u_back_final = q_ne && head.new_block && !blk_done_reg && gen_cnt_reg == 5'd11;

    always_comb
    begin
        head_eff = head;
        head_eff.new_block = head.new_block && !blk_done_reg;
    end

    chacha_back u_back (
        .clk, .rst_n,
        .key0(key0_reg), .key1(key1_reg), .key2(key2_reg), .key3(key3_reg),
        .nonce_val(nonce_reg),
        .q_not_empty(q_ne), .q_head(head_eff), .pop,
        .out_valid, .out_ready, .out_byte
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && restart) |=> u_front.offset_reg == 6'd1)
        else $error("restart did not reset offset");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !head_eff.new_block)
        else $error("item left before its block was built");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blk_done_reg) |-> q_ne)
        else $error("block marked without waiting item");
endmodule

[hw/rtl/chacha_front.sv]
// ----------------------------------------------------------------------------
// ChaCha20 front end
// Accepts items, tracks offset and counter, pushes classified items.
// ----------------------------------------------------------------------------
module chacha_front import chacha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       push,
    output item_t      push_item,
    input  logic       q_full
);
    logic [5:0]  offset_reg;
    logic [63:0] counter_reg;
    logic [5:0]  off_eff;
    logic [63:0] cnt_eff;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign off_eff  = restart ? 6'd0 : offset_reg;
    assign cnt_eff  = restart ? 64'd0 : counter_reg;

    // Classify the item
    always_comb
    begin
        push_item.data      = data_byte;
        push_item.offset    = off_eff;
        push_item.new_block = (off_eff == 6'd0);
        push_item.counter   = cnt_eff;
    end

    // Advance offset and counter per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            counter_reg <= '0;
        end
        else if (push)
        begin
            offset_reg  <= off_eff + 6'd1;
            counter_reg <= (off_eff == 6'd0) ? cnt_eff + 64'd1 : cnt_eff;
        end
    end
endmodule

[hw/rtl/chacha_queue.sv]
// ----------------------------------------------------------------------------
// ChaCha20 item queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
module chacha_queue import chacha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);
    item_t      mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full      = (cnt_reg == 3'd4);
    assign not_empty = (cnt_reg != 3'd0);
    assign head      = mem_reg[rp_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("fill count out of range");
endmodule

[hw/rtl/chacha_back.sv]
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Computes keystream blocks (one double round per cycle) and XORs bytes.
// ----------------------------------------------------------------------------
module chacha_back import chacha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] key0,
    input  logic [63:0] key1,
    input  logic [63:0] key2,
    input  logic [63:0] key3,
    input  logic [63:0] nonce_val,
    input  logic        q_not_empty,
    input  item_t       q_head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte
);
    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINAL} st_t;

    st_t        st_reg;
    state_t     init_reg, work_reg, ks_reg;
    logic [3:0] rnd_reg;
    logic       ov_reg;
    logic [7:0] ob_reg;
    state_t     init_w, dr;
    logic [127:0] t0, t1, t2, t3, u0, u1, u2, u3;
    logic       slot_free, take;
    word_t      ksw;

    assign slot_free = !ov_reg || out_ready;
    assign take      = (st_reg == S_IDLE) && q_not_empty && !q_head.new_block && slot_free;
    assign pop       = take;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign ksw       = ks_reg[q_head.offset[5:2]];

    // Build the initial state
    always_comb
    begin
        init_w[0]  = SIGMA0;            init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;            init_w[3]  = SIGMA3;
        init_w[4]  = key0[31:0];        init_w[5]  = key0[63:32];
        init_w[6]  = key1[31:0];        init_w[7]  = key1[63:32];
        init_w[8]  = key2[31:0];        init_w[9]  = key2[63:32];
        init_w[10] = key3[31:0];        init_w[11] = key3[63:32];
        init_w[12] = q_head.counter[31:0];
        init_w[13] = q_head.counter[63:32];
        init_w[14] = nonce_val[31:0];   init_w[15] = nonce_val[63:32];
    end

    // One double round: columns then diagonals
    always_comb
    begin
        t0 = qr(work_reg[0], work_reg[4], work_reg[8],  work_reg[12]);
        t1 = qr(work_reg[1], work_reg[5], work_reg[9],  work_reg[13]);
        t2 = qr(work_reg[2], work_reg[6], work_reg[10], work_reg[14]);
        t3 = qr(work_reg[3], work_reg[7], work_reg[11], work_reg[15]);
        u0 = qr(t0[127:96], t1[95:64], t2[63:32], t3[31:0]);
        u1 = qr(t1[127:96], t2[95:64], t3[63:32], t0[31:0]);
        u2 = qr(t2[127:96], t3[95:64], t0[63:32], t1[31:0]);
        u3 = qr(t3[127:96], t0[95:64], t1[63:32], t2[31:0]);
        dr[0] = u0[127:96]; dr[5] = u0[95:64]; dr[10] = u0[63:32]; dr[15] = u0[31:0];
        dr[1] = u1[127:96]; dr[6] = u1[95:64]; dr[11] = u1[63:32]; dr[12] = u1[31:0];
        dr[2] = u2[127:96]; dr[7] = u2[95:64]; dr[8]  = u2[63:32]; dr[13] = u2[31:0];
        dr[3] = u3[127:96]; dr[4] = u3[95:64]; dr[9]  = u3[63:32]; dr[14] = u3[31:0];
    end

    // Sequence block generation and hold the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            rnd_reg  <= '0;
            ov_reg   <= 1'b0;
            ob_reg   <= '0;
            init_reg <= '0;
            work_reg <= '0;
            ks_reg   <= '0;
        end
        else
        begin
            // Load the output register on take, drop it once the receiver accepts
            if (take)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (q_not_empty && q_head.new_block)
                    begin
                        init_reg <= init_w;
                        work_reg <= init_w;
                        rnd_reg  <= '0;
                        st_reg   <= S_ROUND;
                    end
                    else if (take)
                    begin
                        ob_reg <= q_head.data ^ 8'(ksw >> {q_head.offset[1:0], 3'b000});
                    end
                end
                S_ROUND:
                begin
                    work_reg <= dr;
                    rnd_reg  <= rnd_reg + 4'd1;
                    if (rnd_reg == 4'(DOUBLE_ROUNDS - 1))
                        st_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    for (int i = 0; i < 16; i++)
                        ks_reg[i] <= work_reg[i] + init_reg[i];
                    // Block is ready: let the opening item go through normally
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // The opening item must not be consumed as new_block again
    // (handled by top: new_block is cleared once the block exists)

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> st_reg == S_IDLE)
        else $error("item consumed during block generation");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_ROUND) |-> rnd_reg < 4'(DOUBLE_ROUNDS))
        else $error("round count overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_byte))
        else $error("result changed while stalled");
endmodule

[tb/chacha20_stream_cipher_test.sv]
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher testbench
// Drives bytes through the valid/ready input, predicts every output byte with
// a local ChaCha20 keystream model and checks results in order. Covers key and
// nonce settings, restarts, long messages and random idling.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_test import chacha_pkg::*;
();
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;

    // Predictor state
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg;
    logic [31:0] ks_words [16];
    logic [5:0]  ks_offset;
    logic [63:0] ks_counter;

    logic [7:0] expected_bytes [$];
    int         mismatches;
    int         idle_cycles;
    int         rx_hold;
    bit         timed_out;
    bit         rx_stall_enable;

    chacha20_stream_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] rot_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Run one quarter round in place on the working words
    function automatic void quarter(ref logic [31:0] w [16], input int a, int b,
                                    int c, int d);
        w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
    endfunction

    // Compute the keystream block for the current counter
    function automatic void compute_keystream_block();
        logic [31:0] init [16];
        logic [31:0] w [16];
        init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
        for (int k = 0; k < 4; k++)
        begin
            init[4 + 2 * k] = key_reg[k][31:0];
            init[5 + 2 * k] = key_reg[k][63:32];
        end
        init[12] = ks_counter[31:0];
        init[13] = ks_counter[63:32];
        init[14] = nonce_reg[31:0];
        init[15] = nonce_reg[63:32];
        w = init;
        for (int r = 0; r < 10; r++)
        begin
            quarter(w, 0, 4, 8, 12);
            quarter(w, 1, 5, 9, 13);
            quarter(w, 2, 6, 10, 14);
            quarter(w, 3, 7, 11, 15);
            quarter(w, 0, 5, 10, 15);
            quarter(w, 1, 6, 11, 12);
            quarter(w, 2, 7, 8, 13);
            quarter(w, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++)
            ks_words[k] = w[k] + init[k];
    endfunction

    // Advance the keystream by one byte and return the ciphered byte
    function automatic logic [7:0] cipher_byte(logic [7:0] din, logic rs);
        logic [31:0] word;
        if (rs)
        begin
            ks_counter = '0;
            ks_offset  = '0;
        end
        if (ks_offset == 0)
        begin
            compute_keystream_block();
            ks_counter = ks_counter + 64'd1;
        end
        word = ks_words[ks_offset[5:2]];
        ks_offset = ks_offset + 6'd1;
        return din ^ word[8 * (ks_offset - 6'd1) % 32 +: 8];
    endfunction

    // Write one register while the block is idle
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_KEY0:  key_reg[0] = value;
            REG_KEY1:  key_reg[1] = value;
            REG_KEY2:  key_reg[2] = value;
            REG_KEY3:  key_reg[3] = value;
            REG_NONCE: nonce_reg  = value;
            default: ;
        endcase
    endtask

    // Drop valid for a random number of cycles, if any
    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Send one item and hold it until accepted
    task automatic send_byte(logic [7:0] din, logic rs, bit gaps);
        in_valid  <= 1'b1;
        data_byte <= din;
        restart   <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_bytes.push_back(cipher_byte(din, rs));
        if (gaps && $urandom_range(0, 2) == 0)
            random_gap();
    endtask

    task automatic finish_send();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected byte has come, plus pipeline slack
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_message(int len, bit gaps);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)), k == 0, gaps);
    endtask

    task automatic write_all_regs(logic [63:0] v [5]);
        write_reg(REG_KEY0, v[0]);
        write_reg(REG_KEY1, v[1]);
        write_reg(REG_KEY2, v[2]);
        write_reg(REG_KEY3, v[3]);
        write_reg(REG_NONCE, v[4]);
    endtask

    // Zero key, no restart after reset, byte extremes
    task automatic test_directed_zero_key();
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hff, 1'b0, 0);
        send_byte(8'h55, 1'b0, 0);
        send_byte(8'haa, 1'b1, 0);
        send_byte(8'h00, 1'b0, 0);
        finish_send();
        drain();
    endtask

    // All-ones key and nonce, a write to an unused index, twenty bytes within one block
    task automatic test_directed_ones_key();
        logic [63:0] v [5];
        foreach (v[k]) v[k] = '1;
        write_all_regs(v);
        write_reg(REG_UNUSED, 64'h0123_4567_89ab_cdef);
        for (int k = 0; k < 20; k++)
            send_byte(k[0] ? 8'hff : 8'h00, k == 0, 0);
        finish_send();
        drain();
    endtask

    // Restart in the middle of a block, then a long stream over several blocks
    task automatic test_counter_wrap();
        send_byte(8'h00, 1'b1, 0);
        finish_send();
        drain();
        send_message(200, 0);
        finish_send();
        drain();
    endtask

    // Random messages under several key and nonce settings
    task automatic test_random_messages(int total);
        logic [63:0] v [5];
        int sent;
        sent = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            foreach (v[k])
                v[k] = (phase == 1) ? 64'd0 : {$urandom(), $urandom()};
            write_all_regs(v);
            rx_stall_enable = (phase != 2);
            while (sent < total * (phase + 1) / 6)
            begin
                int len;
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 200)
                                                  : $urandom_range(1, 70);
                for (int k = 0; k < len; k++)
                    send_byte(8'($urandom_range(0, 255)),
                              k == 0 && $urandom_range(0, 9) != 0, phase != 2);
                sent += len;
            end
            drain();
        end
    endtask

    // Receiver stalls: mostly short, now and then a long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else if (!rx_stall_enable)
            out_ready <= 1'b1;
        else if (rx_hold != 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= $urandom_range(8, 40);
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Compare each output byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output byte %02h", out_byte);
            end
            else
            begin
                logic [7:0] exp_b;
                exp_b = expected_bytes.pop_front();
                if (exp_b !== out_byte)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("out_byte mismatch: expected %02h actual %02h",
                                 exp_b, out_byte);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0; rst_n = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        in_valid = 1'b0; data_byte = '0; restart = 1'b0;
        mismatches = 0; idle_cycles = 0; timed_out = 1'b0;
        rx_stall_enable = 1'b1;
        foreach (key_reg[k]) key_reg[k] = '0;
        nonce_reg = '0; ks_offset = '0; ks_counter = '0;
        foreach (ks_words[k]) ks_words[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_zero_key();
        test_directed_ones_key();
        test_counter_wrap();
        test_random_messages(1400);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
